/* hw/rtl/pisb_pkg.sv */
// Shared constants, register indexes and unit request/response types for the
// PID step core with integral band. No dependencies; every other file imports it.
package pisb_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int PROD_W    = 2 * DATA_W;
	// Divider dividend: a 33-bit error difference shifted left by the fraction bits.
	localparam int DIV_W     = DATA_W + 1 + FRAC_BITS;
	localparam int CFG_IDX_W = 3;

	// Pi in unsigned Q2.32 scaled form, rounded to the nearest fixed-point value.
	localparam logic [63:0] PI_Q32 = 64'd13493037705;
	localparam logic [DATA_W-1:0] PI_FIX =
		DATA_W'((PI_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
	localparam logic [DATA_W-1:0] TWO_PI_FIX = {PI_FIX[DATA_W-2:0], 1'b0};

	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BAND      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MIN = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MAX = 3'd7;

	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] a_mag;
		logic [DATA_W-1:0] b_mag;
		logic              neg;
	} pisb_mul_req_t;

	typedef struct packed {
		logic                     busy;
		logic                     done;
		logic signed [PROD_W-1:0] prod;
	} pisb_mul_rsp_t;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  num_mag;
		logic [DATA_W-1:0] den;
	} pisb_div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DIV_W-1:0]  quo;
		logic [DATA_W-1:0] rem;
	} pisb_div_rsp_t;

endpackage

/* hw/rtl/pid_step_integral_band_core.sv */
// PID step core with integral band: one control step in signed Q16.16 per item.
// A step item runs through the shared bit-serial multiplier, which works up to
// four products, and the restoring divider, which works the derivative and, in
// angle mode, the angle wrap; a clear item needs neither. Items are worked one
// at a time; the next item is taken while a finished result still waits in the
// output register. Depends on pisb_pkg, pisb_mul, pisb_div.
module pid_step_integral_band_core import pisb_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     op,
	input  logic signed [31:0]       measured,
	input  logic [31:0]              time_step,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [31:0]       drive,
	output logic signed [31:0]       error_now,
	output logic signed [31:0]       integral_now,
	output logic signed [31:0]       derivative_now,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [31:0]              cfg_data
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DIFF   = 4'd1;
	localparam logic [3:0] S_WRAP   = 4'd2;
	localparam logic [3:0] S_BAND   = 4'd3;
	localparam logic [3:0] S_INT    = 4'd4;
	localparam logic [3:0] S_INTADD = 4'd5;
	localparam logic [3:0] S_DER    = 4'd6;
	localparam logic [3:0] S_TP     = 4'd7;
	localparam logic [3:0] S_TP_SAT = 4'd8;
	localparam logic [3:0] S_TI     = 4'd9;
	localparam logic [3:0] S_TI_SAT = 4'd10;
	localparam logic [3:0] S_TD     = 4'd11;
	localparam logic [3:0] S_TD_SAT = 4'd12;
	localparam logic [3:0] S_SUM    = 4'd13;
	localparam logic [3:0] S_DONE   = 4'd14;

	localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] SAT_MIN = 32'h8000_0000;

	function automatic logic [31:0] abs32(input logic [31:0] x);
		return x[31] ? (~x + 32'd1) : x;
	endfunction

	function automatic logic [31:0] sat66(input logic signed [65:0] v);
		logic [31:0] r;
		if (v > 66'sd2147483647) begin
			r = SAT_MAX;
		end else if (v < -66'sd2147483648) begin
			r = SAT_MIN;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// Configuration registers.
	logic signed [31:0] gain_p_q;
	logic signed [31:0] gain_i_q;
	logic signed [31:0] gain_d_q;
	logic signed [31:0] target_q;
	logic [30:0]        band_q;
	logic [1:0]         mode_q;
	logic signed [31:0] dmin_q;
	logic signed [31:0] dmax_q;

	// Stored controller state.
	logic signed [31:0] integral_q;
	logic signed [31:0] last_q;

	// Per-item working registers.
	logic [3:0]                state_q;
	logic                      launched_q;
	logic signed [31:0]        meas_q;
	logic [31:0]               dt_q;
	logic [33:0]               wsum_q;
	logic signed [31:0]        err_q;
	logic signed [31:0]        integ_new_q;
	logic signed [31:0]        deriv_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [31:0]        tp_q;
	logic signed [31:0]        ti_q;
	logic signed [31:0]        td_q;
	logic signed [31:0]        u_q;

	logic                      out_valid_q;
	logic signed [31:0]        out_drive_q;
	logic signed [31:0]        out_err_q;
	logic signed [31:0]        out_int_q;
	logic signed [31:0]        out_der_q;

	pisb_mul_req_t mul_req;
	pisb_mul_rsp_t mul_rsp;
	pisb_div_req_t div_req;
	pisb_div_rsp_t div_rsp;

	logic               in_accept;
	logic               load_out;
	logic [32:0]        diff;
	logic [33:0]        wsum;
	logic [33:0]        wsum_abs;
	logic [32:0]        dnum;
	logic [32:0]        dnum_abs;
	logic [32:0]        wrap_mod;
	logic               band_hit;
	logic [PROD_W-1:0]  prod_sh;
	logic [65:0]        int_sum;
	logic [65:0]        term_sum;
	logic [31:0]        u_sat;
	logic               quo_big;
	logic [31:0]        deriv_sat;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign load_out  = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	assign diff     = {target_q[31], target_q} - {meas_q[31], meas_q};
	assign wsum     = {diff[32], diff} + {2'b00, PI_FIX};
	assign wsum_abs = wsum_q[33] ? (~wsum_q + 34'd1) : wsum_q;
	assign dnum     = {err_q[31], err_q} - {last_q[31], last_q};
	assign dnum_abs = dnum[32] ? (~dnum + 33'd1) : dnum;
	// Floor modulo: a negative dividend with a nonzero remainder folds back.
	assign wrap_mod = (wsum_q[33] && (div_rsp.rem != '0)) ?
		({1'b0, TWO_PI_FIX} - {1'b0, div_rsp.rem}) : {1'b0, div_rsp.rem};
	assign band_hit = abs32(err_q) > {1'b0, band_q};
	assign prod_sh  = prod_q >>> FRAC_BITS;
	assign int_sum  = {{34{integral_q[31]}}, integral_q} + {{2{prod_sh[PROD_W-1]}}, prod_sh};
	assign term_sum = {{34{tp_q[31]}}, tp_q} + {{34{ti_q[31]}}, ti_q}
		+ {{34{td_q[31]}}, td_q};
	assign u_sat    = sat66(term_sum);
	assign quo_big  = |div_rsp.quo[DIV_W-1:31];
	assign deriv_sat = dnum[32] ? (quo_big ? SAT_MIN : (~div_rsp.quo[31:0] + 32'd1))
		: (quo_big ? SAT_MAX : div_rsp.quo[31:0]);

	always_comb begin
		div_req.start   = ((state_q == S_WRAP) || (state_q == S_DER)) && !launched_q;
		div_req.num_mag = (state_q == S_WRAP) ? DIV_W'(wsum_abs[32:0])
			: {dnum_abs, {FRAC_BITS{1'b0}}};
		div_req.den     = (state_q == S_WRAP) ? TWO_PI_FIX
			: ((dt_q == '0) ? 32'd1 : dt_q);
	end

	always_comb begin
		mul_req.start = 1'b0;
		mul_req.a_mag = abs32(err_q);
		mul_req.b_mag = dt_q;
		mul_req.neg   = err_q[31];
		case (state_q)
			S_INT: begin
				mul_req.start = !launched_q;
			end
			S_TP: begin
				mul_req.start = !launched_q;
				mul_req.a_mag = abs32(gain_p_q);
				mul_req.b_mag = abs32(err_q);
				mul_req.neg   = gain_p_q[31] ^ err_q[31];
			end
			S_TI: begin
				mul_req.start = !launched_q;
				mul_req.a_mag = abs32(gain_i_q);
				mul_req.b_mag = abs32(integ_new_q);
				mul_req.neg   = gain_i_q[31] ^ integ_new_q[31];
			end
			S_TD: begin
				mul_req.start = !launched_q;
				mul_req.a_mag = abs32(gain_d_q);
				mul_req.b_mag = abs32(deriv_q);
				mul_req.neg   = gain_d_q[31] ^ deriv_q[31];
			end
			default: begin
				mul_req.start = 1'b0;
			end
		endcase
	end

	pisb_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	pisb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q <= '0;
			gain_i_q <= '0;
			gain_d_q <= '0;
			target_q <= '0;
			band_q   <= '0;
			mode_q   <= '0;
			dmin_q   <= '0;
			dmax_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GAIN_P:    gain_p_q <= cfg_data;
				REG_GAIN_I:    gain_i_q <= cfg_data;
				REG_GAIN_D:    gain_d_q <= cfg_data;
				REG_TARGET:    target_q <= cfg_data;
				REG_BAND:      band_q   <= cfg_data[30:0];
				REG_MODE:      mode_q   <= cfg_data[1:0];
				REG_DRIVE_MIN: dmin_q   <= cfg_data;
				REG_DRIVE_MAX: dmax_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			launched_q  <= 1'b0;
			integral_q  <= '0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (mul_req.start || div_req.start) begin
				launched_q <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						if (op) begin
							integral_q <= '0;
							last_q     <= '0;
						end else begin
							state_q <= S_DIFF;
						end
					end
				end
				S_DIFF: begin
					state_q <= mode_q[0] ? S_WRAP : S_BAND;
				end
				S_WRAP: begin
					if (div_rsp.done) begin
						launched_q <= 1'b0;
						state_q    <= S_BAND;
					end
				end
				S_BAND: begin
					state_q <= band_hit ? S_DER : S_INT;
				end
				S_INT: begin
					if (mul_rsp.done) begin
						launched_q <= 1'b0;
						state_q    <= S_INTADD;
					end
				end
				S_INTADD: begin
					state_q <= S_DER;
				end
				S_DER: begin
					if (div_rsp.done) begin
						launched_q <= 1'b0;
						state_q    <= S_TP;
					end
				end
				S_TP: begin
					if (mul_rsp.done) begin
						launched_q <= 1'b0;
						state_q    <= S_TP_SAT;
					end
				end
				S_TP_SAT: begin
					state_q <= S_TI;
				end
				S_TI: begin
					if (mul_rsp.done) begin
						launched_q <= 1'b0;
						state_q    <= S_TI_SAT;
					end
				end
				S_TI_SAT: begin
					state_q <= S_TD;
				end
				S_TD: begin
					if (mul_rsp.done) begin
						launched_q <= 1'b0;
						state_q    <= S_TD_SAT;
					end
				end
				S_TD_SAT: begin
					state_q <= S_SUM;
				end
				S_SUM: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (load_out) begin
						integral_q <= integ_new_q;
						last_q     <= err_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			meas_q <= measured;
			dt_q   <= time_step;
		end
		if (state_q == S_DIFF) begin
			wsum_q <= wsum;
			err_q  <= sat66({{33{diff[32]}}, diff});
		end
		if ((state_q == S_WRAP) && div_rsp.done) begin
			err_q <= 32'(wrap_mod - {1'b0, PI_FIX});
		end
		if ((state_q == S_BAND) && band_hit) begin
			integ_new_q <= '0;
		end
		if (mul_rsp.done) begin
			prod_q <= mul_rsp.prod;
		end
		if (state_q == S_INTADD) begin
			integ_new_q <= sat66(int_sum);
		end
		if ((state_q == S_DER) && div_rsp.done) begin
			deriv_q <= deriv_sat;
		end
		if (state_q == S_TP_SAT) begin
			tp_q <= sat66({{2{prod_sh[PROD_W-1]}}, prod_sh});
		end
		if (state_q == S_TI_SAT) begin
			ti_q <= sat66({{2{prod_sh[PROD_W-1]}}, prod_sh});
		end
		if (state_q == S_TD_SAT) begin
			td_q <= sat66({{2{prod_sh[PROD_W-1]}}, prod_sh});
		end
		if (state_q == S_SUM) begin
			// Where both limits are crossed, the lower one wins.
			if (mode_q[1] && ($signed(u_sat) < dmin_q)) begin
				u_q <= dmin_q;
			end else if (mode_q[1] && ($signed(u_sat) > dmax_q)) begin
				u_q <= dmax_q;
			end else begin
				u_q <= u_sat;
			end
		end
		if (load_out) begin
			out_drive_q <= u_q;
			out_err_q   <= err_q;
			out_int_q   <= integ_new_q;
			out_der_q   <= deriv_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign drive          = out_drive_q;
	assign error_now      = out_err_q;
	assign integral_now   = out_int_q;
	assign derivative_now = out_der_q;

	// The multiplier and the divider are never in use at the same time.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_rsp.busy && div_rsp.busy))
		else $error("multiplier and divider busy together");

	// A clear item leaves the stored integral and last error at zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && op) |=> ((integral_q == '0) && (last_q == '0)))
		else $error("clear item did not zero the controller state");

	// An error outside the band delivers a zero integral.
	assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && band_hit) |=> (integral_now == '0))
		else $error("integral not cleared outside the band");

	// With ordered limits and clamping on, the delivered drive stays inside them.
	assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && mode_q[1] && (dmin_q <= dmax_q))
		|=> ((drive >= $past(dmin_q)) && (drive <= $past(dmax_q))))
		else $error("clamped drive outside its limits");

endmodule

/* hw/rtl/pisb_mul.sv */
// Bit-serial shift-add multiplier on magnitudes with a sign applied at the end.
// Depends on pisb_pkg for widths and the request/response types.
module pisb_mul import pisb_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  pisb_mul_req_t req,
	output pisb_mul_rsp_t rsp
);

	localparam int CNT_W = $clog2(DATA_W);

	logic [DATA_W-1:0] a_q;
	logic [DATA_W-1:0] hi_q;
	logic [DATA_W-1:0] lo_q;
	logic              neg_q;
	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W:0]   sum;
	logic [PROD_W-1:0] mag;

	assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);
	assign mag = {hi_q, lo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DATA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The multiplier bits leave the low word as the product bits enter it.
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a_mag;
			lo_q  <= req.b_mag;
			hi_q  <= '0;
			neg_q <= req.neg;
		end else if (busy_q) begin
			hi_q <= sum[DATA_W:1];
			lo_q <= {sum[0], lo_q[DATA_W-1:1]};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.prod = neg_q ? (~mag + PROD_W'(1)) : mag;

endmodule

/* hw/rtl/pisb_div.sv */
// Restoring divider that produces one quotient bit per cycle on magnitudes.
// Depends on pisb_pkg for widths and the request/response types.
module pisb_div import pisb_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  pisb_div_req_t req,
	output pisb_div_rsp_t rsp
);

	localparam int CNT_W = $clog2(DIV_W);

	logic [DIV_W-1:0]  num_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] den_q;
	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W+1:0] trial;
	logic              fits;

	assign trial = {1'b0, rem_q, num_q[DIV_W-1]} - {2'b00, den_q};
	assign fits  = !trial[DATA_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Dividend bits shift out the top while quotient bits shift in at the bottom.
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num_mag;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_W-2:0], fits};
			rem_q <= fits ? trial[DATA_W-1:0] : {rem_q[DATA_W-2:0], num_q[DIV_W-1]};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = num_q;
	assign rsp.rem  = rem_q;

endmodule
